// ===== sv/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, register codes and CORDIC constants for the range scan
// to Cartesian converter.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int unsigned CORDIC_STEPS = 20;
  localparam int unsigned CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [48:0]   HALF_Q30        = 49'sd536870912;
  localparam logic signed [18:0]   OUT_LIMIT       = 19'sd65535;

  localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10680862,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304
  };

  typedef enum logic [1:0] {
    REG_RANGE_LIMIT = 2'd0,
    REG_ANGLE_START = 2'd1,
    REG_ANGLE_STEP  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cvec_t;

  typedef struct packed {
    logic [15:0] range;
    logic        ok;
    logic [9:0]  idx;
    logic        flip;
  } meta_t;

  function automatic cvec_t cordic_iter(cvec_t a, logic [4:0] i);
    cvec_t r;
    if (a.z >= 0) begin
      r.x = a.x - (a.y >>> i);
      r.y = a.y + (a.x >>> i);
      r.z = a.z - ATAN_TAB[i];
    end else begin
      r.x = a.x + (a.y >>> i);
      r.y = a.y - (a.x >>> i);
      r.z = a.z + ATAN_TAB[i];
    end
    return r;
  endfunction

endpackage

// ===== sv/rsc_if.sv =====
// ----------------------------------------------------------------------------
// rsc_in_if / rsc_out_if
// Valid/ready channels for range samples and Cartesian points.
// ----------------------------------------------------------------------------
interface rsc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        scan_start;

  modport source (output valid, output range_mm, output scan_start, input ready);
  modport sink   (input valid, input range_mm, input scan_start, output ready);
endinterface

interface rsc_out_if;
  logic              valid;
  logic              ready;
  logic signed [16:0] x_mm;
  logic signed [16:0] y_mm;
  logic              point_valid;
  logic [9:0]        sample_index;

  modport source (output valid, output x_mm, output y_mm, output point_valid,
                  output sample_index, input ready);
  modport sink   (input valid, input x_mm, input y_mm, input point_valid,
                  input sample_index, output ready);
endinterface

// ===== sv/range_scan_to_cartesian.sv =====
// ----------------------------------------------------------------------------
// range_scan_to_cartesian
// Converts laser range samples to x/y points with a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries range_mm and scan_start; a sample transfers when valid and
//   ready are high at a rising clock edge. scan_start reloads the beam angle
//   from angle_start and the sample index from zero. The angle advances by
//   angle_step after every sample; the index counts up and saturates.
//   out_ch carries one point per sample, in order: x = range*sin, y =
//   range*cos, zero with point_valid low when range_mm >= range_limit_mm.
//   Configuration: cfg_we writes cfg_wdata to register cfg_idx; unknown
//   indexes are ignored. Write only while the pipeline is empty.
// Timing:
//   13 stages: input register, ten CORDIC stages of two rotations each, a
//   multiply stage and the output register. Samples pass through them in
//   that order; one sample per cycle is sustained while out_ch.ready is high.
//   Each stage holds when the next one is full and stalled, so empty stages
//   keep filling while out_ch.ready is low; in_ch.ready drops only when all
//   stages hold data.
//   Reset clears the stage valid flags, the beam angle and index, and loads the
//   register defaults (limit 3000, start 0, step 0).
// ----------------------------------------------------------------------------
module range_scan_to_cartesian
  import rsc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rsc_in_if.sink      in_ch,
  rsc_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned CAP_INT  = (MAX_POINTS - 1 > 1023) ? 1023 : MAX_POINTS - 1;
  localparam logic [9:0]  IDX_CAP  = 10'(CAP_INT);
  localparam int unsigned DROP     = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
  localparam logic [15:0] ANGLE_MASK = 16'(17'h0FFFF << DROP);
  localparam int unsigned NCORD    = CORDIC_STEPS / 2;
  localparam int unsigned MSTG     = NCORD + 1;
  localparam int unsigned NSTG     = NCORD + 3;

  logic [15:0] limit_r, start_r, step_r;
  logic [15:0] angle_r, angle_nxt;
  logic [9:0]  idx_r, idx_nxt;

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   ld;
  cvec_t           c_r [NCORD+1];
  meta_t           m_r [MSTG+1];
  logic signed [48:0] px_r, py_r;
  logic signed [16:0] xo_r, yo_r;
  logic               pv_r;
  logic [9:0]         io_r;

  logic        in_fire;
  logic [15:0] ang_use, ang_m;
  logic [9:0]  idx_use;
  logic        flip;
  logic [15:0] ph;

  function automatic logic signed [16:0] round_sat(logic signed [48:0] p);
    logic signed [48:0] s;
    logic signed [18:0] q;
    s = p + HALF_Q30;
    q = 19'(s >>> 30);
    if (q > OUT_LIMIT) begin
      q = OUT_LIMIT;
    end else if (q < -OUT_LIMIT) begin
      q = -OUT_LIMIT;
    end
    return q[16:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 16'd3000;
      start_r <= '0;
      step_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RANGE_LIMIT: limit_r <= cfg_wdata;
        REG_ANGLE_START: start_r <= cfg_wdata;
        REG_ANGLE_STEP:  step_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ld[NSTG] = out_ch.ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_ld
    assign ld[k] = !v_r[k] || ld[k+1];
  end

  assign in_ch.ready = ld[0];
  assign in_fire     = in_ch.valid && ld[0];

  always_comb begin
    ang_use   = in_ch.scan_start ? start_r : angle_r;
    idx_use   = in_ch.scan_start ? 10'd0 : idx_r;
    angle_nxt = ang_use + step_r;
    idx_nxt   = (idx_use < IDX_CAP) ? idx_use + 10'd1 : idx_use;
    ang_m     = ang_use & ANGLE_MASK;
    flip      = ang_m[15] ^ ang_m[14];
    ph        = {ang_m[15] ^ flip, ang_m[14:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      idx_r   <= '0;
    end else if (in_fire) begin
      angle_r <= angle_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      c_r[0].x   <= CORDIC_GAIN_Q30;
      c_r[0].y   <= '0;
      c_r[0].z   <= {{2{ph[15]}}, ph, 16'h0000};
      m_r[0].range <= in_ch.range_mm;
      m_r[0].ok    <= in_ch.range_mm < limit_r;
      m_r[0].idx   <= idx_use;
      m_r[0].flip  <= flip;
    end
  end

  for (genvar g = 0; g < NCORD; g++) begin : g_cordic
    cvec_t t, u;
    always_comb begin
      t = cordic_iter(c_r[g], 5'(2 * g));
      u = cordic_iter(t, 5'(2 * g + 1));
    end
    always_ff @(posedge clk) begin
      if (ld[g+1]) begin
        c_r[g+1] <= u;
        m_r[g+1] <= m_r[g];
      end
    end
  end

  logic signed [31:0] cos_q, sin_q;
  always_comb begin
    cos_q = m_r[NCORD].flip ? -c_r[NCORD].x[31:0] : c_r[NCORD].x[31:0];
    sin_q = m_r[NCORD].flip ? -c_r[NCORD].y[31:0] : c_r[NCORD].y[31:0];
  end

  always_ff @(posedge clk) begin
    if (ld[MSTG]) begin
      px_r       <= $signed({1'b0, m_r[NCORD].range}) * sin_q;
      py_r       <= $signed({1'b0, m_r[NCORD].range}) * cos_q;
      m_r[MSTG]  <= m_r[NCORD];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NSTG-1]) begin
      xo_r <= m_r[MSTG].ok ? round_sat(px_r) : 17'sd0;
      yo_r <= m_r[MSTG].ok ? round_sat(py_r) : 17'sd0;
      pv_r <= m_r[MSTG].ok;
      io_r <= m_r[MSTG].idx;
    end
  end

  assign out_ch.valid        = v_r[NSTG-1];
  assign out_ch.x_mm         = xo_r;
  assign out_ch.y_mm         = yo_r;
  assign out_ch.point_valid  = pv_r;
  assign out_ch.sample_index = io_r;

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.point_valid |-> out_ch.x_mm == 17'sd0 && out_ch.y_mm == 17'sd0)
    else $error("rejected point carries nonzero coordinates");

  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.x_mm != -17'sd65536 && out_ch.y_mm != -17'sd65536)
    else $error("coordinate outside saturation limit");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.scan_start |=> idx_r == 10'd1)
    else $error("index not restarted on scan start");

  a_scan_angle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.scan_start && !cfg_we |=> angle_r == $past(16'(start_r + step_r)))
    else $error("beam angle not reloaded on scan start");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ch.ready)
    else $error("input stalled with empty input stage");

endmodule
